@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, including during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/nrbm_pkg.sv @@
`timescale 1ns / 1ps

package nrbm_pkg;

    // Bus and field widths
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_AW      = 18;
    localparam int WIN_W       = 14;
    localparam int BANK_W      = 4;
    localparam int NIB_W       = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Nibble RAM geometry
    localparam int RAM_DEPTH = 512;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int PIDX_LSB  = 2;

    // Codes
    localparam logic CMD_READ     = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;
    localparam logic REG_BANK_MASK = 1'b0;

    // Reset and fill values
    localparam logic [BANK_W-1:0] MASK_RST  = 4'hF;
    localparam logic [BANK_W-1:0] BANK_RST  = 4'h1;
    localparam logic [BANK_W-1:0] BANK_ZERO = 4'h0;
    localparam logic [DATA_W-1:0] DATA_NONE = 8'hFF;
    localparam logic [NIB_W-1:0]  NIB_CLEAR = 4'h0;

    // One write to the nibble RAM
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [NIB_W-1:0]  data;
    } t_ram_wr;

endpackage

@@ rtl/core/nibble_ram_rom_bank_mapper_unit.sv @@
`timescale 1ns / 1ps

// Bank controller for a cartridge bus with a 4-bit ROM bank and a 512 x 4 RAM.
// Input stream (s side): one CPU bus access per item. tuser is the command
// (0 read, 1 write); tdata carries the address and the write byte.
// Output stream (m side): exactly one result item per access, in order.
// tuser flags mapped and from_rom; tdata holds the ROM address and read data.
// Throughput: one item per cycle while the output is not stalled; state updates
// and the RAM read happen at the accept edge, so each item sees every earlier
// write. The RAM's single read port sets the rate.
// Reset: the bank mask goes to 15, the bank to 1 and RAM is enabled. The RAM
// is then swept to zero, one entry per cycle, through all 512 entries;
// s_tready stays low during the sweep. APB writes are taken out of reset, sweep included.
// Stall: a result waits in the output register while m_tready is low; one more
// item is taken into the input stage, after which s_tready drops until the
// output drains.
module nibble_ram_rom_bank_mapper_unit
    import nrbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] address, [23:16] write_data
    input  logic                   i_s_tuser,   // [0] command
    // Output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [17:0] rom_address, [25:18] read_data
    output logic [1:0]             o_m_tuser,   // [0] mapped, [1] from_rom
    // Configuration
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    output logic [PDATA_W-1:0]     o_prdata,
    output logic                   o_pready
);

    `include "assert_macros.svh"

    // Control state
    logic [BANK_W-1:0] r_mask;
    logic [BANK_W-1:0] r_bank,     n_bank;
    logic              r_ram_dis;
    logic [RAM_AW:0]   r_clr_cnt;
    logic              clr_done;

    // Pipeline
    logic              r_s1_vld;
    logic              r_s1_mapped;
    logic              r_s1_from_rom;
    logic [ROM_AW-1:0] r_s1_rom_addr;
    logic [DATA_W-1:0] r_s1_rdata;
    logic              r_s1_use_nib;
    logic              r_out_vld;
    logic              r_out_mapped;
    logic              r_out_from_rom;
    logic [ROM_AW-1:0] r_out_rom_addr;
    logic [DATA_W-1:0] r_out_rdata;

    logic              acc, out_free, s1_move, is_wr;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_wdata;
    logic              rom_area, rom_lo, ctl_area, bank_area, ram_area, ram_nib;
    logic              mapped_c, from_rom_c, use_nib_c;
    logic [ROM_AW-1:0] rom_addr_c;
    logic [DATA_W-1:0] rdata_c;
    logic [NIB_W-1:0]  ram_q;
    t_ram_wr           ram_wr;
    logic              cfg_wr;
    logic              out_rom;

    // Handshake
    assign clr_done   = r_clr_cnt[RAM_AW];
    assign out_free   = !r_out_vld || i_m_tready;
    assign s1_move    = r_s1_vld && out_free;
    assign o_s_tready = clr_done && (!r_s1_vld || out_free);
    assign acc        = i_s_tvalid && o_s_tready;

    // Address decode
    assign in_addr   = i_s_tdata[ADDR_W-1:0];
    assign in_wdata  = i_s_tdata[ADDR_W +: DATA_W];
    assign is_wr     = (i_s_tuser == CMD_WRITE);
    assign rom_area  = !in_addr[15];
    assign rom_lo    = (in_addr[15:14] == 2'b00);
    assign ctl_area  = (in_addr[15:13] == 3'b000);
    assign bank_area = (in_addr[15:13] == 3'b001) && in_addr[8];
    assign ram_area  = (in_addr[15:13] == 3'b101);
    assign ram_nib   = ram_area && (in_addr[12:RAM_AW] == '0);
    assign mapped_c  = rom_area || ram_area;

    // Result fields for reads; all zero on writes
    always_comb begin
        from_rom_c = 1'b0;
        rom_addr_c = '0;
        rdata_c    = '0;
        use_nib_c  = 1'b0;
        if (!is_wr) begin
            if (rom_area) begin
                from_rom_c = 1'b1;
                if (rom_lo) begin
                    rom_addr_c = {{(ROM_AW-WIN_W){1'b0}}, in_addr[WIN_W-1:0]};
                end else begin
                    rom_addr_c = {r_bank & r_mask, in_addr[WIN_W-1:0]};
                end
            end else if (ram_area) begin
                rdata_c   = DATA_NONE;
                use_nib_c = ram_nib && !r_ram_dis;
            end
        end
    end

    // Bank select, zero maps to one
    assign n_bank = (in_wdata[BANK_W-1:0] == BANK_ZERO) ? BANK_RST : in_wdata[BANK_W-1:0];

    // Control registers and RAM clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= BANK_RST;
            r_ram_dis <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            if (!clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (acc && is_wr && ctl_area) begin
                r_ram_dis <= in_addr[8];
            end
            if (acc && is_wr && bank_area) begin
                r_bank <= n_bank;
            end
        end
    end

    // RAM write: sweep first, then item writes
    always_comb begin
        if (!clr_done) begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = r_clr_cnt[RAM_AW-1:0];
            ram_wr.data = NIB_CLEAR;
        end else begin
            ram_wr.we   = acc && is_wr && ram_nib;
            ram_wr.addr = in_addr[RAM_AW-1:0];
            ram_wr.data = in_wdata[NIB_W-1:0];
        end
    end

    nrbm_nibble_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (acc),
        .i_rd_addr (in_addr[RAM_AW-1:0]),
        .o_rd_data (ram_q)
    );

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mapped   <= mapped_c;
            r_s1_from_rom <= from_rom_c;
            r_s1_rom_addr <= rom_addr_c;
            r_s1_rdata    <= rdata_c;
            r_s1_use_nib  <= use_nib_c;
        end
        if (s1_move) begin
            r_out_mapped   <= r_s1_mapped;
            r_out_from_rom <= r_s1_from_rom;
            r_out_rom_addr <= r_s1_rom_addr;
            r_out_rdata    <= r_s1_use_nib ? {{(DATA_W-NIB_W){1'b0}}, ram_q} : r_s1_rdata;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W-ROM_AW-DATA_W){1'b0}}, r_out_rdata, r_out_rom_addr};
    assign o_m_tuser  = {r_out_from_rom, r_out_mapped};

    // Configuration port
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr[PIDX_LSB] == REG_BANK_MASK);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[PIDX_LSB] == REG_BANK_MASK) ?
                      {{(PDATA_W-BANK_W){1'b0}}, r_mask} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RST;
        end else if (cfg_wr) begin
            r_mask <= i_pwdata[BANK_W-1:0];
        end
    end

    // Checks
    assign out_rom = r_out_vld && r_out_from_rom;

    `ASSERT_CLK(a_no_accept_in_sweep, !clr_done |-> !o_s_tready, "item accepted during RAM sweep")
    `ASSERT_CLK(a_bank_nonzero, r_bank != BANK_ZERO, "stored ROM bank is zero")
    `ASSERT_CLK(a_rom_implies_mapped, out_rom |-> r_out_mapped, "ROM result not mapped")
    `ASSERT_CLK(a_rom_no_rdata, out_rom |-> (r_out_rdata == '0), "ROM read carries RAM data")

endmodule

@@ rtl/core/nrbm_nibble_ram.sv @@
`timescale 1ns / 1ps

module nrbm_nibble_ram
    import nrbm_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [RAM_AW-1:0] i_rd_addr,
    output logic [NIB_W-1:0]  o_rd_data
);

    logic [NIB_W-1:0] r_mem [RAM_DEPTH];
    logic [NIB_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port, read-before-write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import nrbm_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT = 5000;     // cycles with no item moving on either side
    localparam int HOLD_CYCLES = 200;      // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;      // result latency plus margin
    localparam int MAX_PRINTS = 40;
    localparam int REG_UNUSED = 1;         // register index with nothing behind it

    // One CPU bus access as driven into the block
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } bus_access_t;

    // One decoded result as the block should return it
    typedef struct packed {
        logic              mapped;
        logic              from_rom;
        logic [ROM_AW-1:0] rom_addr;
        logic [DATA_W-1:0] rdata;
    } map_result_t;

    // Mirror of the bank controller state plus the queue of predicted results
    class bank_map_scoreboard;
        logic [BANK_W-1:0] bank_mask;
        logic [BANK_W-1:0] cur_bank;
        logic              ram_off;
        logic [NIB_W-1:0]  nibbles [RAM_DEPTH];
        map_result_t       pending_results [$];
        int                errors;
        int                results_seen;
        int                accesses_seen;

        function new();
            bank_mask = MASK_RST;
            cur_bank = BANK_RST;
            ram_off = 1'b0;
            foreach (nibbles[i]) nibbles[i] = NIB_CLEAR;
            errors = 0;
            results_seen = 0;
            accesses_seen = 0;
        endfunction

        function void write_register(int idx, logic [PDATA_W-1:0] value);
            if (idx == int'(REG_BANK_MASK)) bank_mask = value[BANK_W-1:0];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] result %0d: %s got %0h, expected %0h",
                         $realtime, results_seen, what, got, want);
        endfunction

        // Decode one accepted access and update the mirrored state
        function void note_access(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wd);
            map_result_t r;
            logic [RAM_AW-1:0] idx;
            r = '0;
            idx = addr[RAM_AW-1:0];
            accesses_seen++;
            if (addr < 16'h8000) begin
                r.mapped = 1'b1;
                if (cmd == CMD_WRITE) begin
                    if (addr < 16'h2000) begin
                        ram_off = addr[8];
                    end else if (addr < 16'h4000 && addr[8]) begin
                        cur_bank = (wd[BANK_W-1:0] == BANK_ZERO) ? BANK_RST : wd[BANK_W-1:0];
                    end
                end else begin
                    r.from_rom = 1'b1;
                    if (addr < 16'h4000)
                        r.rom_addr = {2'b00, addr};
                    else
                        r.rom_addr = {cur_bank & bank_mask, addr[WIN_W-1:0]};
                end
            end else if (addr >= 16'hA000 && addr < 16'hC000) begin
                r.mapped = 1'b1;
                if (cmd == CMD_WRITE) begin
                    if (addr < 16'hA200) nibbles[idx] = wd[NIB_W-1:0];
                end else begin
                    if (addr < 16'hA200 && !ram_off)
                        r.rdata = {4'h0, nibbles[idx]};
                    else
                        r.rdata = DATA_NONE;
                end
            end
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [1:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
            map_result_t r;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", 32'(tdata), 32'h0);
                return;
            end
            r = pending_results.pop_front();
            if (tuser[0] !== r.mapped)
                report_mismatch("mapped", 32'(tuser[0]), 32'(r.mapped));
            if (tuser[1] !== r.from_rom)
                report_mismatch("from_rom", 32'(tuser[1]), 32'(r.from_rom));
            if (tdata[17:0] !== r.rom_addr)
                report_mismatch("rom_address", 32'(tdata[17:0]), 32'(r.rom_addr));
            if (tdata[25:18] !== r.rdata)
                report_mismatch("read_data", 32'(tdata[25:18]), 32'(r.rdata));
            if (tdata[31:26] !== 6'h0)
                report_mismatch("tdata padding", 32'(tdata[31:26]), 32'h0);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [15:0] address, [23:16] write_data
    logic                   i_s_tuser;   // [0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [17:0] rom_address, [25:18] read_data
    logic [1:0]             o_m_tuser;   // [0] mapped, [1] from_rom
    logic                   i_psel;
    logic                   i_penable;
    logic                   i_pwrite;
    logic [PADDR_W-1:0]     i_paddr;
    logic [PDATA_W-1:0]     i_pwdata;
    logic [PDATA_W-1:0]     o_prdata;
    logic                   o_pready;

    bank_map_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_gen;
    int hold_seen;
    int hold_left;
    int stall_count;
    int items_sent;

    nibble_ram_rom_bank_mapper_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // Clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Sample both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                sb.note_access(i_s_tuser, i_s_tdata[15:0], i_s_tdata[23:16]);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        hold_seen = 0;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_gen != hold_seen) begin
                hold_seen = hold_gen;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
            end
        end
    end

    // Offer one access, with random idle cycles before it
    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wd);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {wd, addr};
        i_s_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access phase until pready
    task automatic apb_write(input int idx, input logic [PDATA_W-1:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= PADDR_W'(idx << PIDX_LSB);
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.write_register(idx, value);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    // Random access, weighted toward the decoded windows
    function automatic bus_access_t pick_access();
        bus_access_t a;
        int r;
        r = int'($urandom_range(99));
        a.cmd = 1'($urandom_range(1));
        a.addr = 16'($urandom_range(16'hFFFF));
        a.wdata = 8'($urandom_range(8'hFF));
        if (r < 30) begin
            // nibble RAM, often a few hot entries so reads hit earlier writes
            if ($urandom_range(1) == 0)
                a.addr = 16'hA000 | 16'($urandom_range(15));
            else
                a.addr = 16'hA000 | 16'($urandom_range(RAM_DEPTH - 1));
        end else if (r < 35) begin
            a.addr = 16'($urandom_range(16'hBFFF, 16'hA200));
        end else if (r < 55) begin
            a.cmd = CMD_READ;
            a.addr = 16'($urandom_range(16'h7FFF));
        end else if (r < 65) begin
            a.cmd = CMD_WRITE;
            a.addr = 16'h2100 | 16'($urandom_range(16'h1FFF));
        end else if (r < 71) begin
            a.cmd = CMD_WRITE;
            a.addr = 16'($urandom_range(16'h1FFF));
        end else if (r < 78) begin
            a.cmd = CMD_WRITE;
            a.addr = 16'($urandom_range(16'h7FFF, 16'h2000));
        end
        return a;
    endfunction

    // Main sequence
    initial begin
        logic [BANK_W-1:0] phase_masks [NUM_PHASES];
        bus_access_t a;
        phase_masks = '{4'h0, 4'h3, 4'hF, 4'h1, 4'h7, 4'hF};
        sb = new();
        send_idle_pct = 36;
        recv_idle_pct = 55;
        hold_gen = 0;
        items_sent = 0;
        stall_count <= 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= CMD_READ;
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= '0;
        i_pwdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: window edges, bank zero, ignored writes, disabled RAM
        send_item(CMD_READ, 16'h0000, 8'h00);
        send_item(CMD_READ, 16'h3FFF, 8'hFF);
        send_item(CMD_READ, 16'h4000, 8'h00);
        send_item(CMD_WRITE, 16'h2100, 8'hF0);   // bank 0 turns into bank 1
        send_item(CMD_READ, 16'h7FFF, 8'h00);
        send_item(CMD_WRITE, 16'h3FFF, 8'hFF);   // bank 15
        send_item(CMD_READ, 16'h5555, 8'h00);
        send_item(CMD_WRITE, 16'h2000, 8'h07);   // bit 8 clear, no effect
        send_item(CMD_WRITE, 16'h7FFF, 8'h02);   // ROM window write, no effect
        send_item(CMD_READ, 16'h4000, 8'h00);
        send_item(CMD_WRITE, 16'hA000, 8'hFF);
        send_item(CMD_WRITE, 16'hA1FF, 8'h05);
        send_item(CMD_READ, 16'hA000, 8'h00);
        send_item(CMD_READ, 16'hA1FF, 8'h00);
        send_item(CMD_WRITE, 16'hBFFF, 8'h0C);   // past the RAM, no effect
        send_item(CMD_READ, 16'hA200, 8'h00);
        send_item(CMD_READ, 16'h8000, 8'hFF);
        send_item(CMD_WRITE, 16'h9FFF, 8'hFF);
        send_item(CMD_READ, 16'hFFFF, 8'h00);
        send_item(CMD_WRITE, 16'h1FFF, 8'h00);   // disable RAM
        send_item(CMD_WRITE, 16'hA001, 8'h39);   // still stored while disabled
        send_item(CMD_READ, 16'hA001, 8'h00);
        send_item(CMD_WRITE, 16'h1EFF, 8'hFF);   // bit 8 clear: enable again
        send_item(CMD_READ, 16'hA001, 8'h00);
        send_item(CMD_READ, 16'hA1FF, 8'h00);
        drain();

        // Random phases, each setting a bank mask and an idle profile
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 2) ? 36 : (p < 4) ? 55 : 0;
            recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 36 : 0;
            apb_write(int'(REG_BANK_MASK), 32'(phase_masks[p]));
            if (p == 2) apb_write(REG_UNUSED, 32'h0);
            if (p == 4) hold_gen++;   // receiver stalls while items keep coming
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                a = pick_access();
                send_item(a.cmd, a.addr, a.wdata);
            end
            drain();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d accesses, checked %0d results over %0d bank mask settings",
                 items_sent, sb.results_seen, NUM_PHASES + 1);
        $display("Covered ROM, RAM and unmapped windows under three idle profiles");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/nrbm_pkg.sv
rtl/core/nrbm_nibble_ram.sv
rtl/core/nibble_ram_rom_bank_mapper_unit.sv
test/tb_top.sv
